// ===== hdl/fpsa_pkg.sv =====
// Shared types, codes and constants of the fit policy segment allocator.
package fpsa_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam logic [15:0] ARENA_RESET = 16'd1024;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;
	localparam logic [1:0] POL_NEXT  = 2'd3;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_ARENA  = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] size;
		logic        used;
	} seg_t;

	typedef struct packed {
		logic    init_wr;
		logic    load;
		logic    scan;
		logic    alloc_prep;
		logic    free_rd;
		logic    free_cap;
		logic    free_merge;
		logic    shift;
		logic    alloc_w1;
		logic    alloc_w2;
		logic    nfp_clear;
		logic    res_valid;
		status_t res_status;
	} ctl_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic zero_req;
		logic split;
		logic full;
		logic is_free;
		logic has_next;
		logic shift_done;
		logic pol_next;
	} sts_t;

endpackage

// ===== hdl/fit_policy_segment_allocator.sv =====
// Top level of the fit policy segment allocator.
//
//  channel | handshake                 | word
//  --------+---------------------------+-------------------------------------------
//  request | start, accepted when !busy| cmd, request_size, block_offset
//  result  | done, one cycle strobe    | status, granted_offset
//  config  | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Busy covers a scan of the segment table, a decision state, and then the table reads and
// writes and the shift of the later entries that the free or alloc path needs.
// The result strobe comes in the same cycle that busy drops. The segment memory has one
// read and one write port and is read one entry per cycle, so the time busy grows with the
// number of segments. After reset the block writes the initial hole before it accepts
// a word. The receiver cannot stall; each result is shown for exactly one cycle.
module fit_policy_segment_allocator #(
	parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [15:0] request_size,
	input  logic [15:0] block_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] granted_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import fpsa_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	fpsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	fpsa_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.request_size   (request_size),
		.block_offset   (block_offset),
		.done           (done),
		.status         (status),
		.granted_offset (granted_offset)
	);

endmodule

// ===== hdl/fpsa_datapath.sv =====
// Datapath of the allocator: segment memory, scan, shift engine and result registers.
module fpsa_datapath #(
	parameter int MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fpsa_pkg::ctl_t ctl,
	output fpsa_pkg::sts_t sts,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           cmd,
	input  logic [15:0]    request_size,
	input  logic [15:0]    block_offset,
	output logic           done,
	output logic [1:0]     status,
	output logic [15:0]    granted_offset
);
	import fpsa_pkg::*;

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	seg_t mem_q [MAX_SEGMENTS];
	seg_t rd_data_s1;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	seg_t          wr_data;
	logic [IW-1:0] rd_addr;

	logic [1:0]    policy_q;
	logic [15:0]   arena_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] nfp_q;

	logic          is_free_q;
	logic [15:0]   req_q;
	logic [15:0]   off_q;

	logic [IW-1:0] sidx_q;
	logic [CW-1:0] steps_q;
	logic          sv_s1;

	logic          found_q;
	logic [IW-1:0] pick_idx_q;
	seg_t          pick_q;
	seg_t          prev_q;
	seg_t          last_q;
	seg_t          next_q;

	logic [IW-1:0] sh_rd_q;
	logic [CW-1:0] sh_left_q;
	logic          sh_up_q;
	logic [1:0]    sh_del_q;
	logic          shv_s1;
	logic [IW-1:0] shsrc_s1;

	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   granted_q;

	logic          fits, take, early, split, has_next;
	logic [CW-1:0] sidx_inc;
	logic [IW-1:0] start_idx;
	logic          mn, mp;
	logic [15:0]   cur_sz;
	seg_t          merged;
	logic [IW-1:0] base;
	logic [CW-1:0] src0, moves;
	logic [1:0]    del;
	logic [IW-1:0] nfp1, nfp2, nfp_alloc;
	logic [CW-1:0] nfp_after;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	assign fits     = !rd_data_s1.used && (rd_data_s1.size >= req_q);
	assign early    = is_free_q || (policy_q == POL_FIRST) || (policy_q == POL_NEXT);
	assign split    = pick_q.size != req_q;
	assign has_next = (CW'(pick_idx_q) + CW'(1)) < count_q;
	assign sidx_inc = CW'(sidx_q) + CW'(1);
	assign start_idx = (policy_q == POL_NEXT && cmd == CMD_ALLOC && CW'(nfp_q) < count_q) ?
		nfp_q : '0;

	always_comb begin
		if (is_free_q) begin
			take = rd_data_s1.used && rd_data_s1.offset == off_q && !found_q;
		end else begin
			case (policy_q)
				POL_BEST:  take = fits && (!found_q || rd_data_s1.size < pick_q.size);
				POL_WORST: take = fits && (!found_q || rd_data_s1.size > pick_q.size);
				default:   take = fits && !found_q;
			endcase
		end
	end

	assign mn     = has_next && !next_q.used;
	assign mp     = (pick_idx_q != '0) && !prev_q.used;
	assign cur_sz = pick_q.size + (mn ? next_q.size : 16'd0);
	assign base   = mp ? pick_idx_q - IW'(1) : pick_idx_q;
	assign src0   = CW'(pick_idx_q) + CW'(1) + CW'(mn);
	assign moves  = (mn || mp) ? count_q - src0 : '0;
	assign del    = {1'b0, mn} + {1'b0, mp};
	assign nfp1   = (mn && CW'(nfp_q) >= CW'(pick_idx_q) + CW'(1)) ? nfp_q - IW'(1) : nfp_q;
	assign nfp2   = (mp && nfp1 >= pick_idx_q) ? nfp1 - IW'(1) : nfp1;

	always_comb begin
		if (mp) begin
			merged = '{offset: prev_q.offset, size: prev_q.size + cur_sz, used: 1'b0};
		end else begin
			merged = '{offset: pick_q.offset, size: cur_sz, used: 1'b0};
		end
	end

	assign nfp_after = CW'(pick_idx_q) + (split ? CW'(2) : CW'(1));

	always_comb begin
		if (policy_q == POL_NEXT) begin
			nfp_alloc = has_next ? nfp_after[IW-1:0] : '0;
		end else if (split && nfp_q > pick_idx_q) begin
			nfp_alloc = nfp_q + IW'(1);
		end else begin
			nfp_alloc = nfp_q;
		end
	end

	always_comb begin
		if (ctl.free_rd) begin
			rd_addr = pick_idx_q + IW'(1);
		end else if (ctl.shift) begin
			rd_addr = sh_rd_q;
		end else begin
			rd_addr = sidx_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (cfg_we && cfg_index == REG_ARENA) begin
			wr_en   = 1'b1;
			wr_data = '{offset: 16'd0, size: cfg_data, used: 1'b0};
		end else if (ctl.init_wr) begin
			wr_en   = 1'b1;
			wr_data = '{offset: 16'd0, size: arena_q, used: 1'b0};
		end else if (ctl.shift && shv_s1) begin
			wr_en   = 1'b1;
			wr_addr = sh_up_q ? shsrc_s1 + IW'(1) : shsrc_s1 - IW'(sh_del_q);
			wr_data = rd_data_s1;
		end else if (ctl.free_merge) begin
			wr_en   = 1'b1;
			wr_addr = base;
			wr_data = merged;
		end else if (ctl.alloc_w1) begin
			wr_en   = 1'b1;
			wr_addr = pick_idx_q + IW'(1);
			wr_data = '{offset: pick_q.offset + req_q, size: pick_q.size - req_q, used: 1'b0};
		end else if (ctl.alloc_w2) begin
			wr_en   = 1'b1;
			wr_addr = pick_idx_q;
			wr_data = '{offset: pick_q.offset, size: req_q, used: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= POL_FIRST;
			arena_q   <= ARENA_RESET;
			count_q   <= CW'(1);
			nfp_q     <= '0;
			steps_q   <= '0;
			sv_s1     <= 1'b0;
			found_q   <= 1'b0;
			sh_left_q <= '0;
			shv_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_POLICY) begin
				policy_q <= cfg_data[1:0];
			end
			if (cfg_we && cfg_index == REG_ARENA) begin
				arena_q <= cfg_data;
				count_q <= CW'(1);
				nfp_q   <= '0;
			end

			if (ctl.load) begin
				steps_q <= count_q;
				sv_s1   <= 1'b0;
				found_q <= 1'b0;
			end else if (ctl.scan) begin
				if (steps_q != '0) begin
					sv_s1   <= 1'b1;
					steps_q <= steps_q - CW'(1);
				end else begin
					sv_s1 <= 1'b0;
				end
				if (sv_s1 && take) begin
					found_q <= 1'b1;
				end
			end

			if (ctl.alloc_prep) begin
				sh_left_q <= split ? count_q - CW'(1) - CW'(pick_idx_q) : '0;
				shv_s1    <= 1'b0;
			end else if (ctl.free_merge) begin
				sh_left_q <= moves;
				shv_s1    <= 1'b0;
				nfp_q     <= nfp2;
				count_q   <= count_q - CW'(del);
			end else if (ctl.shift) begin
				if (sh_left_q != '0) begin
					shv_s1    <= 1'b1;
					sh_left_q <= sh_left_q - CW'(1);
				end else begin
					shv_s1 <= 1'b0;
				end
			end

			if (ctl.alloc_w2) begin
				nfp_q   <= nfp_alloc;
				count_q <= count_q + CW'(split);
			end
			if (ctl.nfp_clear) begin
				nfp_q <= '0;
			end

			done_q <= ctl.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			is_free_q <= cmd != CMD_ALLOC;
			req_q     <= request_size;
			off_q     <= block_offset;
			sidx_q    <= start_idx;
		end else if (ctl.scan) begin
			if (steps_q != '0) begin
				sidx_q <= (sidx_inc == count_q) ? '0 : sidx_inc[IW-1:0];
			end
			if (sv_s1) begin
				last_q <= rd_data_s1;
				if (take) begin
					pick_idx_q <= (sidx_q == '0) ? IW'(count_q - CW'(1)) : sidx_q - IW'(1);
					pick_q     <= rd_data_s1;
					prev_q     <= last_q;
				end
			end
		end
		if (ctl.free_cap) begin
			next_q <= rd_data_s1;
		end
		if (ctl.alloc_prep) begin
			sh_up_q <= 1'b1;
			sh_rd_q <= IW'(count_q - CW'(1));
		end else if (ctl.free_merge) begin
			sh_up_q  <= 1'b0;
			sh_rd_q  <= src0[IW-1:0];
			sh_del_q <= del;
		end else if (ctl.shift && sh_left_q != '0) begin
			shsrc_s1 <= sh_rd_q;
			sh_rd_q  <= sh_up_q ? sh_rd_q - IW'(1) : sh_rd_q + IW'(1);
		end
		if (ctl.res_valid) begin
			status_q  <= ctl.res_status;
			granted_q <= (ctl.res_status == ST_OK && !is_free_q) ? pick_q.offset : 16'd0;
		end
	end

	assign sts.scan_done  = (steps_q == '0 && !sv_s1) || (early && found_q);
	assign sts.found      = found_q;
	assign sts.zero_req   = req_q == 16'd0;
	assign sts.split      = split;
	assign sts.full       = split && (count_q >= CW'(MAX_SEGMENTS));
	assign sts.is_free    = is_free_q;
	assign sts.has_next   = has_next;
	assign sts.shift_done = (sh_left_q == '0) && !shv_s1;
	assign sts.pol_next   = policy_q == POL_NEXT;

	assign done           = done_q;
	assign status         = status_q;
	assign granted_offset = granted_q;

endmodule

// ===== hdl/fpsa_ctrl.sv =====
// Controller state machine that sequences scan, shift and table updates.
module fpsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fpsa_pkg::sts_t sts,
	output fpsa_pkg::ctl_t ctl
);
	import fpsa_pkg::*;

	typedef enum logic [9:0] {
		S_INIT   = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_SCAN   = 10'b0000000100,
		S_DECIDE = 10'b0000001000,
		S_FRD    = 10'b0000010000,
		S_FCAP   = 10'b0000100000,
		S_FMERGE = 10'b0001000000,
		S_SHIFT  = 10'b0010000000,
		S_AW1    = 10'b0100000000,
		S_AW2    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_INIT: begin
				ctl.init_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_free) begin
					if (!sts.found) begin
						ctl.res_valid  = 1'b1;
						ctl.res_status = ST_BADFREE;
						state_d        = S_IDLE;
					end else if (sts.has_next) begin
						state_d = S_FRD;
					end else begin
						state_d = S_FMERGE;
					end
				end else if (sts.zero_req || !sts.found) begin
					ctl.res_valid  = 1'b1;
					ctl.res_status = ST_NOFIT;
					ctl.nfp_clear  = !sts.zero_req && sts.pol_next;
					state_d        = S_IDLE;
				end else if (sts.full) begin
					ctl.res_valid  = 1'b1;
					ctl.res_status = ST_FULL;
					state_d        = S_IDLE;
				end else begin
					ctl.alloc_prep = 1'b1;
					state_d        = S_SHIFT;
				end
			end
			S_FRD: begin
				ctl.free_rd = 1'b1;
				state_d     = S_FCAP;
			end
			S_FCAP: begin
				ctl.free_cap = 1'b1;
				state_d      = S_FMERGE;
			end
			S_FMERGE: begin
				ctl.free_merge = 1'b1;
				state_d        = S_SHIFT;
			end
			S_SHIFT: begin
				ctl.shift = 1'b1;
				if (sts.shift_done) begin
					if (sts.is_free) begin
						ctl.res_valid  = 1'b1;
						ctl.res_status = ST_OK;
						state_d        = S_IDLE;
					end else if (sts.split) begin
						state_d = S_AW1;
					end else begin
						state_d = S_AW2;
					end
				end
			end
			S_AW1: begin
				ctl.alloc_w1 = 1'b1;
				state_d      = S_AW2;
			end
			S_AW2: begin
				ctl.alloc_w2   = 1'b1;
				ctl.res_valid  = 1'b1;
				ctl.res_status = ST_OK;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ===== hdl/fpsa_checker.sv =====
// Port level checker of the fit policy segment allocator and its bind.
module fpsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] granted_offset
);
	import fpsa_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in progress");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result strobes in a row");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_offset == 16'd0)
		else $error("nonzero offset on a failed request");

endmodule

bind fit_policy_segment_allocator fpsa_checker u_fpsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.granted_offset (granted_offset)
);
